// ===== rtl/pss_pkg.sv =====
package pss_pkg;

  localparam int MAX_MOTIF_LEN = 32;
  localparam int ROW_W = $clog2(MAX_MOTIF_LEN);
  localparam int LEN_W = 6;
  localparam int WEIGHT_BITS = 16;
  localparam int SCORE_W = 21;
  localparam int COL_W = 2;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int CODE_W = 3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  typedef logic [CODE_W-1:0] code_t;

  localparam code_t CODE_A = 3'd0;
  localparam code_t CODE_C = 3'd1;
  localparam code_t CODE_G = 3'd2;
  localparam code_t CODE_T = 3'd3;
  localparam code_t CODE_BAD = 3'd4;

  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_UC = 8'h43;
  localparam logic [7:0] CHAR_LC = 8'h63;
  localparam logic [7:0] CHAR_UG = 8'h47;
  localparam logic [7:0] CHAR_LG = 8'h67;
  localparam logic [7:0] CHAR_UT = 8'h54;
  localparam logic [7:0] CHAR_LT = 8'h74;

  typedef struct packed {
    logic push;
    logic step;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic rd_en;
    logic [ROW_W-1:0] row;
    code_t code;
  } acc_ctrl_t;

  function automatic code_t base_code(input logic [7:0] ch);
    code_t c;
    case (ch)
      CHAR_UA, CHAR_LA: c = CODE_A;
      CHAR_UC, CHAR_LC: c = CODE_C;
      CHAR_UG, CHAR_LG: c = CODE_G;
      CHAR_UT, CHAR_LT: c = CODE_T;
      default: c = CODE_BAD;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/pss_cell.sv =====
module pss_cell (
  input  logic                clk,
  input  pss_pkg::cell_ctrl_t ctrl,
  input  pss_pkg::code_t      win_in,
  input  pss_pkg::code_t      scan_in,
  output pss_pkg::code_t      win,
  output pss_pkg::code_t      scan
);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      win <= win_in;
      scan <= win_in;
    end else if (ctrl.step) begin
      scan <= scan_in;
    end
  end

endmodule

// ===== rtl/pss_acc.sv =====
module pss_acc (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   we,
  input  logic [pss_pkg::ROW_W-1:0]              wr_row,
  input  logic [pss_pkg::COL_W-1:0]              wr_col,
  input  logic signed [pss_pkg::WEIGHT_BITS-1:0] wr_data,
  input  pss_pkg::acc_ctrl_t                     ctrl,
  output logic signed [pss_pkg::SCORE_W-1:0]     acc,
  output logic                                   bad
);

  localparam int DEPTH = 1 << pss_pkg::ADDR_W;
  localparam int EXT_W = pss_pkg::SCORE_W - pss_pkg::WEIGHT_BITS;

  logic signed [pss_pkg::WEIGHT_BITS-1:0] mem [DEPTH];
  logic signed [pss_pkg::WEIGHT_BITS-1:0] rd_data;
  logic rd_valid;
  logic rd_bad;
  logic signed [pss_pkg::SCORE_W-1:0] rd_ext;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[{wr_row, wr_col}] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[{ctrl.row, ctrl.code[pss_pkg::COL_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= ctrl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_bad <= (ctrl.code == pss_pkg::CODE_BAD);
  end

  assign rd_ext = {{EXT_W{rd_data[pss_pkg::WEIGHT_BITS-1]}}, rd_data};

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
      bad <= 1'b0;
    end else if (rd_valid) begin
      bad <= bad | rd_bad;
      if (!rd_bad) begin
        acc <= acc + rd_ext;
      end
    end
  end

endmodule

// ===== rtl/pwm_sequence_scan.sv =====
// A load, or a push that does not complete a window, leaves the block idle. A push
// that completes a window of m bases reads it out of the cell chain one base per
// cycle into a single weight memory read port and accumulator; the next beat is
// taken once the output register is free and the result has been loaded into it.
// Reset clears the fill count and control state and sets motif_length to 1;
// the weights are undefined until loaded.
module pwm_sequence_scan (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   motif_length_we,
  input  logic [pss_pkg::LEN_W-1:0]              motif_length,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   op,
  input  logic [pss_pkg::ROW_W-1:0]              row,
  input  logic [pss_pkg::COL_W-1:0]              column,
  input  logic signed [pss_pkg::WEIGHT_BITS-1:0] weight,
  input  logic [7:0]                             base_char,
  input  logic                                   first_of_sequence,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [pss_pkg::SCORE_W-1:0]     score,
  output logic                                   valid_res
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  localparam int N = pss_pkg::MAX_MOTIF_LEN;
  localparam logic [pss_pkg::LEN_W-1:0] LEN_MAX = pss_pkg::LEN_W'(N);
  localparam logic [pss_pkg::LEN_W-1:0] LEN_ONE = pss_pkg::LEN_W'(1);
  localparam logic [pss_pkg::ROW_W-1:0] ROW_ONE = pss_pkg::ROW_W'(1);

  state_t state;
  state_t state_next;
  logic [pss_pkg::LEN_W-1:0] motif_len;
  logic [pss_pkg::LEN_W-1:0] len_eff;
  logic [pss_pkg::ROW_W-1:0] len_last;
  logic [pss_pkg::LEN_W-1:0] fill_count;
  logic [pss_pkg::LEN_W-1:0] fill_count_next;
  logic [pss_pkg::ROW_W-1:0] step_idx;
  logic accept;
  logic push;
  logic load_out;

  pss_pkg::code_t win_codes [N];
  pss_pkg::code_t scan_codes [N];
  pss_pkg::cell_ctrl_t cell_ctrl;
  pss_pkg::acc_ctrl_t acc_ctrl;
  logic signed [pss_pkg::SCORE_W-1:0] acc;
  logic bad;

  always_comb begin
    if (motif_len == '0) begin
      len_eff = LEN_ONE;
    end else if (motif_len > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = motif_len;
    end
  end

  assign len_last = pss_pkg::ROW_W'(len_eff - LEN_ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      motif_len <= LEN_ONE;
    end else if (motif_length_we) begin
      motif_len <= motif_length;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign push = accept && (op == pss_pkg::OP_PUSH);

  always_comb begin
    if (first_of_sequence) begin
      fill_count_next = LEN_ONE;
    end else if (fill_count == LEN_MAX) begin
      fill_count_next = LEN_MAX;
    end else begin
      fill_count_next = fill_count + LEN_ONE;
    end
  end

  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (push && (fill_count_next >= len_eff)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step_idx == len_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill_count <= '0;
      step_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        fill_count <= fill_count_next;
      end
      if (state == ST_SCAN) begin
        step_idx <= step_idx + ROW_ONE;
      end else begin
        step_idx <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      score <= bad ? '0 : acc;
      valid_res <= !bad;
    end
  end

  assign cell_ctrl.push = push;
  assign cell_ctrl.step = (state == ST_SCAN);

  for (genvar k = 0; k < N; k++) begin : g_cell
    pss_pkg::code_t win_in;
    pss_pkg::code_t scan_in;
    if (k == 0) begin : g_head
      assign win_in = pss_pkg::base_code(base_char);
      assign scan_in = pss_pkg::CODE_BAD;
    end else begin : g_body
      assign win_in = win_codes[k-1];
      assign scan_in = scan_codes[k-1];
    end
    pss_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .win_in  (win_in),
      .scan_in (scan_in),
      .win     (win_codes[k]),
      .scan    (scan_codes[k])
    );
  end

  assign acc_ctrl.clear = push;
  assign acc_ctrl.rd_en = (state == ST_SCAN);
  assign acc_ctrl.row = step_idx;
  assign acc_ctrl.code = scan_codes[len_last];

  pss_acc u_acc (
    .clk     (clk),
    .rst     (rst),
    .we      (accept && (op == pss_pkg::OP_LOAD)),
    .wr_row  (row),
    .wr_col  (column),
    .wr_data (weight),
    .ctrl    (acc_ctrl),
    .acc     (acc),
    .bad     (bad)
  );

endmodule

// ===== tb/sv/pss_score_checker.sv =====
`timescale 1ns / 1ps

module pss_score_checker
  import pss_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          motif_length_we,
  input  logic [LEN_W-1:0]              motif_length,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          op,
  input  logic [ROW_W-1:0]              row,
  input  logic [COL_W-1:0]              column,
  input  logic signed [WEIGHT_BITS-1:0] weight,
  input  logic [7:0]                    base_char,
  input  logic                          first_of_sequence,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [SCORE_W-1:0]     score,
  input  logic                          valid_res,
  output int                            fail_count,
  output int                            pending,
  output int                            checked,
  output int                            flagged
);

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      valid_res;
  } window_score_t;

  logic signed [WEIGHT_BITS-1:0] matrix [MAX_MOTIF_LEN*4];
  code_t                         recent [MAX_MOTIF_LEN];
  int unsigned                   seen;
  logic [LEN_W-1:0]              len_reg;
  window_score_t                 scores_due [$];

  // Case is folded by clearing bit 5, which only merges each letter with its lowercase twin.
  function automatic code_t classify(input logic [7:0] ch);
    logic [7:0] up;
    up = ch & 8'hDF;
    if (up == CHAR_UA) return CODE_A;
    if (up == CHAR_UC) return CODE_C;
    if (up == CHAR_UG) return CODE_G;
    if (up == CHAR_UT) return CODE_T;
    return CODE_BAD;
  endfunction

  function automatic int unsigned window_span();
    if (len_reg == 0) return 1;
    if (len_reg > MAX_MOTIF_LEN) return MAX_MOTIF_LEN;
    return len_reg;
  endfunction

  // Window position j counts from the oldest base, which sits deepest in the history.
  function automatic window_score_t score_window();
    window_score_t r;
    int unsigned   m;
    int            total;
    code_t         c;
    m = window_span();
    total = 0;
    r.valid_res = 1'b1;
    for (int j = 0; j < m; j++) begin
      c = recent[ROW_W'(m - 1 - j)];
      if (c == CODE_BAD) r.valid_res = 1'b0;
      else total += int'(matrix[{ROW_W'(j), c[COL_W-1:0]}]);
    end
    r.score = r.valid_res ? total[SCORE_W-1:0] : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    window_score_t got, want;
    if (rst) begin
      foreach (matrix[i]) matrix[i] = '0;
      foreach (recent[i]) recent[i] = CODE_A;
      seen = 0;
      len_reg = 1;
      scores_due.delete();
    end else begin
      if (motif_length_we) len_reg = motif_length;
      if (out_valid && out_ready) begin
        got.score = score;
        got.valid_res = valid_res;
        if (scores_due.size() == 0) begin
          $error("unexpected score beat: score %0d, valid_res %0d", score, valid_res);
          fail_count++;
        end else begin
          want = scores_due.pop_front();
          checked++;
          if (!want.valid_res) flagged++;
          if (got.score !== want.score) begin
            $error("score: expected %0d, actual %0d", want.score, got.score);
            fail_count++;
          end
          if (got.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, actual %0d", want.valid_res, got.valid_res);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (op == OP_LOAD) begin
          matrix[{row, column}] = weight;
        end else begin
          if (first_of_sequence) begin
            foreach (recent[i]) recent[i] = CODE_A;
            seen = 0;
          end
          for (int i = MAX_MOTIF_LEN - 1; i > 0; i--) begin
            recent[ROW_W'(i)] = recent[ROW_W'(i - 1)];
          end
          recent[0] = classify(base_char);
          if (seen < MAX_MOTIF_LEN) seen++;
          if (seen >= window_span()) scores_due.push_back(score_window());
        end
      end
    end
    pending = scores_due.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pss_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = MAX_MOTIF_LEN + 8;

  localparam logic [COL_W-1:0] COL_A = 2'd0;
  localparam logic [COL_W-1:0] COL_T = 2'd3;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_MOTIF_LEN - 1);
  localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MAX = 16'sh7FFF;
  localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MIN = 16'sh8000;
  localparam logic [7:0] CHAR_N = 8'h4E;
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_FF = 8'hFF;

  typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN} fill_mode_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          motif_length_we = 1'b0;
  logic [LEN_W-1:0]              motif_length = LEN_W'(1);
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          op = OP_PUSH;
  logic [ROW_W-1:0]              row = '0;
  logic [COL_W-1:0]              column = '0;
  logic signed [WEIGHT_BITS-1:0] weight = '0;
  logic [7:0]                    base_char = '0;
  logic                          first_of_sequence = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SCORE_W-1:0]     score;
  logic                          valid_res;

  int fail_count;
  int pending;
  int checked;
  int flagged;
  int cycles = 0;
  int beats = 0;
  int loads = 0;
  int phases = 0;
  bit calm = 1'b0;

  logic [7:0] dna_chars [8] = '{CHAR_UA, CHAR_LA, CHAR_UC, CHAR_LC,
                                CHAR_UG, CHAR_LG, CHAR_UT, CHAR_LT};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pwm_sequence_scan u_top (
    .clk               (clk),
    .rst               (rst),
    .motif_length_we   (motif_length_we),
    .motif_length      (motif_length),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .op                (op),
    .row               (row),
    .column            (column),
    .weight            (weight),
    .base_char         (base_char),
    .first_of_sequence (first_of_sequence),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .score             (score),
    .valid_res         (valid_res)
  );

  pss_score_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .motif_length_we   (motif_length_we),
    .motif_length      (motif_length),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .op                (op),
    .row               (row),
    .column            (column),
    .weight            (weight),
    .base_char         (base_char),
    .first_of_sequence (first_of_sequence),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .score             (score),
    .valid_res         (valid_res),
    .fail_count        (fail_count),
    .pending           (pending),
    .checked           (checked),
    .flagged           (flagged)
  );

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("pwm_sequence_scan regression: fail");
      $finish;
    end
  end

  task automatic send_beat(input logic o, input logic [ROW_W-1:0] r,
                           input logic [COL_W-1:0] c,
                           input logic signed [WEIGHT_BITS-1:0] w,
                           input logic [7:0] ch, input logic f);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    row <= r;
    column <= c;
    weight <= w;
    base_char <= ch;
    first_of_sequence <= f;
    beats++;
    if (o == OP_LOAD) loads++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                      input logic signed [WEIGHT_BITS-1:0] w);
    send_beat(OP_LOAD, r, c, w, 8'($urandom), 1'($urandom));
  endtask

  task automatic push(input logic [7:0] ch, input logic f);
    send_beat(OP_PUSH, ROW_W'($urandom), COL_W'($urandom), WEIGHT_BITS'($urandom), ch, f);
  endtask

  function automatic logic signed [WEIGHT_BITS-1:0] random_weight();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return WEIGHT_MAX;
    if (r < 10) return WEIGHT_MIN;
    return WEIGHT_BITS'($urandom);
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(99) < 85) return dna_chars[3'($urandom_range(7))];
    return 8'($urandom_range(255));
  endfunction

  // The block must be idle before the length register may change.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] v);
    motif_length_we <= 1'b1;
    motif_length <= v;
    @(posedge clk);
    motif_length_we <= 1'b0;
  endtask

  task automatic load_matrix(input fill_mode_t mode);
    logic signed [WEIGHT_BITS-1:0] w;
    for (int r = 0; r < MAX_MOTIF_LEN; r++) begin
      for (int c = 0; c < 4; c++) begin
        case (mode)
          FILL_MAX: w = WEIGHT_MAX;
          FILL_MIN: w = WEIGHT_MIN;
          default: w = random_weight();
        endcase
        load(ROW_W'(r), COL_W'(c), w);
      end
    end
  endtask

  task automatic saturated_run(input int n);
    for (int i = 0; i < n; i++) push(dna_chars[3'($urandom_range(7))], i == 0);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) load(ROW_W'($urandom), COL_W'($urandom), random_weight());
      else push(pick_char(), (i == 0 && $urandom_range(1) == 1) || $urandom_range(99) < 2);
    end
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return LEN_W'($urandom_range(1, 8));
    if (r < 70) return LEN_W'($urandom_range(9, MAX_MOTIF_LEN));
    if (r < 78) return 0;
    if (r < 86) return LEN_W'(MAX_MOTIF_LEN);
    if (r < 94) return LEN_W'($urandom_range(MAX_MOTIF_LEN + 1, 63));
    return 1;
  endfunction

  initial begin
    int start;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    load_matrix(FILL_RANDOM);

    // Corner rows and columns, then every base letter in both cases and three non-bases, with a length of one.
    load(0, COL_A, WEIGHT_MAX);
    load(0, COL_T, WEIGHT_MIN);
    load(ROW_LAST, COL_A, WEIGHT_MIN);
    load(ROW_LAST, COL_T, WEIGHT_MAX);
    foreach (dna_chars[i]) push(dna_chars[i], 1'b0);
    push(CHAR_N, 1'b0);
    push(CHAR_NUL, 1'b1);
    push(CHAR_FF, 1'b0);
    settle();
    set_length(3);
    push(CHAR_UA, 1'b1);
    push(CHAR_LC, 1'b0);
    push(CHAR_UG, 1'b0);
    push(CHAR_N, 1'b0);
    push(CHAR_UT, 1'b0);
    push(CHAR_LT, 1'b0);
    push(CHAR_LG, 1'b0);
    settle();
    set_length(2);
    push(CHAR_UA, 1'b0);

    start = beats;
    settle();
    set_length(63);
    load_matrix(FILL_MAX);
    saturated_run(40);
    settle();
    set_length(MAX_MOTIF_LEN);
    load_matrix(FILL_MIN);
    saturated_run(40);
    settle();
    set_length(0);
    load_matrix(FILL_RANDOM);
    random_phase(30);

    while (beats - start < RANDOM_ITEMS) begin
      settle();
      calm = (phases % 6 == 4);
      set_length(pick_length());
      if (phases % 9 == 8) load_matrix(FILL_RANDOM);
      random_phase(calm ? 150 : $urandom_range(20, 80));
      phases++;
    end
    settle();
    calm = 1'b0;

    $display("Drove %0d beats (%0d weight loads) over %0d random phases, window lengths 0 to 63.",
             beats, loads, phases);
    $display("Checked %0d window scores, %0d of them flagged as holding a non-ACGT base.",
             checked, flagged);
    if (fail_count == 0) begin
      $display("pwm_sequence_scan regression: pass");
    end else begin
      $display("pwm_sequence_scan regression: fail");
    end
    $finish;
  end

endmodule
